// File: rtl/npps_pkg.sv
// Shared types and constants of the nearest path point search block.
package npps_pkg;

    // Request kinds on the input channel.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Fixed field widths.
    localparam int HEAD_BITS = 16;
    localparam int DIST_BITS = 50;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Control that travels with each point through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } npps_tag_t;

endpackage

// File: rtl/npps_dist.sv
// Three-stage squared Euclidean distance pipeline for one stored point per cycle.
module npps_dist
    import npps_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int IDX_W      = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  npps_tag_t                 in_tag,
    input  logic [IDX_W-1:0]          in_idx,
    input  logic [COORD_BITS-1:0]     in_x,
    input  logic [COORD_BITS-1:0]     in_y,
    input  logic [HEAD_BITS-1:0]      in_h,
    input  logic [COORD_BITS-1:0]     qx,
    input  logic [COORD_BITS-1:0]     qy,
    output npps_tag_t                 out_tag,
    output logic [IDX_W-1:0]          out_idx,
    output logic [COORD_BITS-1:0]     out_x,
    output logic [COORD_BITS-1:0]     out_y,
    output logic [HEAD_BITS-1:0]      out_h,
    output logic [2*COORD_BITS+2:0]   out_dist
);

    localparam int MAG_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * MAG_W;

    logic [MAG_W-1:0] dx, dy, ax_next, ay_next;
    logic [MAG_W-1:0] ax_reg, ay_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic [SQ_W:0]    dist_reg;

    npps_tag_t t1_reg, t2_reg, t3_reg;
    logic [IDX_W-1:0]      i1_reg, i2_reg, i3_reg;
    logic [COORD_BITS-1:0] x1_reg, x2_reg, x3_reg;
    logic [COORD_BITS-1:0] y1_reg, y2_reg, y3_reg;
    logic [HEAD_BITS-1:0]  h1_reg, h2_reg, h3_reg;

    // Differences are exact in one extra bit; the magnitude of the most
    // negative difference still fits unsigned in that width.
    always_comb begin
        dx      = {in_x[COORD_BITS-1], in_x} - {qx[COORD_BITS-1], qx};
        dy      = {in_y[COORD_BITS-1], in_y} - {qy[COORD_BITS-1], qy};
        ax_next = dx[MAG_W-1] ? (~dx + MAG_W'(1)) : dx;
        ay_next = dy[MAG_W-1] ? (~dy + MAG_W'(1)) : dy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end else begin
            t1_reg <= in_tag;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        sqx_reg  <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sqy_reg  <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        dist_reg <= (SQ_W + 1)'(sqx_reg) + (SQ_W + 1)'(sqy_reg);
        i1_reg <= in_idx;
        i2_reg <= i1_reg;
        i3_reg <= i2_reg;
        x1_reg <= in_x;
        x2_reg <= x1_reg;
        x3_reg <= x2_reg;
        y1_reg <= in_y;
        y2_reg <= y1_reg;
        y3_reg <= y2_reg;
        h1_reg <= in_h;
        h2_reg <= h1_reg;
        h3_reg <= h2_reg;
    end

    assign out_tag  = t3_reg;
    assign out_idx  = i3_reg;
    assign out_x    = x3_reg;
    assign out_y    = y3_reg;
    assign out_h    = h3_reg;
    assign out_dist = dist_reg;

endmodule

// File: rtl/nearest_path_point_search.sv
// Nearest path point search: point store, scan sequencer and result register.
//
// The block holds up to MAX_POINTS path points (x, y, heading) in one
// synchronous memory. Requests arrive on the s_ channel (valid/ready); the
// kind field selects clear, append or query. Clear and append may follow
// one another back to back; an append to a full store is dropped, and
// kind 3 is accepted and ignored. Neither gives a result. A query reads
// the stored points in index order, one per cycle through the single read
// port of the memory, so the scan length sets how long a query occupies
// the block. Each point passes the read, three distance stages and one
// compare stage before the output register loads; an empty store answers
// without a scan, with found low. Ties keep the lowest index; dist_sq
// saturates at all ones.
// The result sits in an output register on the m_ channel. While it waits
// for m_ready the block still takes clear and append requests; a further
// query runs its scan and then holds its result until the register frees.
// Reset (aresetn low, synchronous) empties the store and drops any result
// in flight; the memory itself is not cleared, a fill count guards it.
module nearest_path_point_search
    import npps_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_valid,
    output logic                                            s_ready,
    input  logic [1:0]                                      s_kind,
    input  logic signed [COORD_BITS-1:0]                    s_pos_x,
    input  logic signed [COORD_BITS-1:0]                    s_pos_y,
    input  logic signed [HEAD_BITS-1:0]                     s_point_heading,
    output logic                                            m_valid,
    input  logic                                            m_ready,
    output logic                                            m_found,
    output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] m_nearest_index,
    output logic signed [COORD_BITS-1:0]                    m_nearest_x,
    output logic signed [COORD_BITS-1:0]                    m_nearest_y,
    output logic signed [HEAD_BITS-1:0]                     m_ref_heading,
    output logic [DIST_BITS-1:0]                            m_dist_sq
);

    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ENT_W  = 2 * COORD_BITS + HEAD_BITS;
    localparam int DIST_W = 2 * (COORD_BITS + 1) + 1;
    localparam int DEXT_W = (DIST_W > DIST_BITS) ? DIST_W : DIST_BITS;

    // Point store: one entry holds heading, y and x side by side.
    logic [ENT_W-1:0] mem [MAX_POINTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    npps_tag_t        rd_tag_reg;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [COORD_BITS-1:0] qx_reg, qy_reg;
    logic             accept, mem_we, issue, issue_last, query_start, out_free;

    // Distance pipeline results.
    npps_tag_t             res_tag;
    logic [IDX_W-1:0]      res_idx;
    logic [COORD_BITS-1:0] res_x, res_y;
    logic [HEAD_BITS-1:0]  res_h;
    logic [DIST_W-1:0]     res_dist;

    // Running best of the current query.
    logic                  best_found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [COORD_BITS-1:0] best_x_reg, best_y_reg;
    logic [HEAD_BITS-1:0]  best_h_reg;
    logic [DIST_W-1:0]     best_dist_reg;
    logic [DEXT_W-1:0]     best_ext;
    logic [DIST_BITS-1:0]  dist_sat;

    // Output register.
    logic                  m_valid_reg;
    logic                  m_found_reg;
    logic [IDX_W-1:0]      m_idx_reg;
    logic [COORD_BITS-1:0] m_x_reg, m_y_reg;
    logic [HEAD_BITS-1:0]  m_h_reg;
    logic [DIST_BITS-1:0]  m_dist_reg;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign issue_last = (CNT_W'(addr_reg) == count_reg - CNT_W'(1));

    // Sequencer. Writes happen only when idle and reads matter only while
    // scanning, so the two memory ports never touch the same entry at once.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        mem_we      = 1'b0;
        issue       = 1'b0;
        query_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_CLEAR: begin
                            count_next = '0;
                        end
                        KIND_APPEND: begin
                            if (count_reg < CNT_W'(MAX_POINTS)) begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_QUERY: begin
                            query_start = 1'b1;
                            addr_next   = '0;
                            state_next  = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                issue     = 1'b1;
                addr_next = addr_reg + IDX_W'(1);
                if (issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (res_tag.valid && res_tag.last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            addr_reg   <= '0;
            rd_tag_reg <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            rd_tag_reg <= '{valid: issue, last: issue && issue_last};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[IDX_W-1:0]] <= {s_point_heading, s_pos_y, s_pos_x};
        end
        rd_data_reg <= mem[addr_reg];
        rd_idx_reg  <= addr_reg;
        if (query_start) begin
            qx_reg <= s_pos_x;
            qy_reg <= s_pos_y;
        end
    end

    npps_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (rd_tag_reg),
        .in_idx   (rd_idx_reg),
        .in_x     (rd_data_reg[COORD_BITS-1:0]),
        .in_y     (rd_data_reg[2*COORD_BITS-1:COORD_BITS]),
        .in_h     (rd_data_reg[ENT_W-1:2*COORD_BITS]),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .out_tag  (res_tag),
        .out_idx  (res_idx),
        .out_x    (res_x),
        .out_y    (res_y),
        .out_h    (res_h),
        .out_dist (res_dist)
    );

    // Compare stage: the first point always loads, later ones only when
    // strictly closer, so the lowest index wins a tie. A query clears the
    // best so that an empty store reports all zeros.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
        end else if (query_start) begin
            best_found_reg <= 1'b0;
        end else if (res_tag.valid) begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (query_start) begin
            best_idx_reg  <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_h_reg    <= '0;
            best_dist_reg <= '0;
        end else if (res_tag.valid && (!best_found_reg || res_dist < best_dist_reg)) begin
            best_idx_reg  <= res_idx;
            best_x_reg    <= res_x;
            best_y_reg    <= res_y;
            best_h_reg    <= res_h;
            best_dist_reg <= res_dist;
        end
    end

    // The reported distance saturates; the comparison above uses full width.
    assign best_ext = DEXT_W'(best_dist_reg);
    assign dist_sat = ((best_ext >> DIST_BITS) != '0) ? '1 : best_ext[DIST_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_found_reg <= best_found_reg;
            m_idx_reg   <= best_idx_reg;
            m_x_reg     <= best_x_reg;
            m_y_reg     <= best_y_reg;
            m_h_reg     <= best_h_reg;
            m_dist_reg  <= dist_sat;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_nearest_index = m_idx_reg;
    assign m_nearest_x     = m_x_reg;
    assign m_nearest_y     = m_y_reg;
    assign m_ref_heading   = m_h_reg;
    assign m_dist_sq       = m_dist_reg;

endmodule

// File: rtl/npps_checker.sv
// Port-level checks for the nearest path point search, bound to the top level.
module npps_checker
    import npps_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input logic                                            aclk,
    input logic                                            aresetn,
    input logic                                            s_valid,
    input logic                                            s_ready,
    input logic [1:0]                                      s_kind,
    input logic                                            m_valid,
    input logic                                            m_ready,
    input logic                                            m_found,
    input logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] m_nearest_index,
    input logic signed [COORD_BITS-1:0]                    m_nearest_x,
    input logic signed [COORD_BITS-1:0]                    m_nearest_y,
    input logic signed [HEAD_BITS-1:0]                     m_ref_heading,
    input logic [DIST_BITS-1:0]                            m_dist_sq
);

    // A result waiting for the receiver holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_nearest_index)
            && $stable(m_dist_sq) && $stable(m_nearest_x))
        else $error("result changed while stalled");

    // No result survives a reset.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A query occupies the block for at least the next cycle.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == KIND_QUERY |=> !s_ready)
        else $error("request taken right after a query");

    // An empty-store answer carries all-zero fields.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_nearest_index == '0 && m_nearest_x == '0
            && m_nearest_y == '0 && m_ref_heading == '0 && m_dist_sq == '0)
        else $error("empty-store result has non-zero fields");

endmodule

bind nearest_path_point_search npps_checker #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
) u_npps_checker (.*);

// File: sim/tb_nearest_path_point_search.sv
// Self-checking testbench for the nearest path point search block.
`timescale 1ns / 100ps

module tb_nearest_path_point_search
    import npps_pkg::*;
();

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;
    localparam int IDX_BITS   = 10;
    localparam int LIMIT      = 4_000_000;

    // Kind 3 has no name in the package; the block accepts and ignores it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam longint DIST_MAX = (64'sd1 <<< DIST_BITS) - 1;
    localparam logic signed [COORD_BITS-1:0] COORD_MIN =
        COORD_BITS'(-(1 << (COORD_BITS - 1)));
    localparam logic signed [COORD_BITS-1:0] COORD_MAX =
        COORD_BITS'((1 << (COORD_BITS - 1)) - 1);

    // One expected answer to a query.
    typedef struct packed {
        logic                         found;
        logic [IDX_BITS-1:0]          index;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [HEAD_BITS-1:0]  heading;
        logic [DIST_BITS-1:0]         dist_sq;
    } nearest_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [1:0]                   s_kind = KIND_CLEAR;
    logic signed [COORD_BITS-1:0] s_pos_x = '0;
    logic signed [COORD_BITS-1:0] s_pos_y = '0;
    logic signed [HEAD_BITS-1:0]  s_point_heading = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_found;
    logic [IDX_BITS-1:0]          m_nearest_index;
    logic signed [COORD_BITS-1:0] m_nearest_x;
    logic signed [COORD_BITS-1:0] m_nearest_y;
    logic signed [HEAD_BITS-1:0]  m_ref_heading;
    logic [DIST_BITS-1:0]         m_dist_sq;

    // The testbench's own copy of the path store, kept in step with the
    // requests the block has accepted.
    logic signed [COORD_BITS-1:0] path_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] path_y [MAX_POINTS];
    logic signed [HEAD_BITS-1:0]  path_heading [MAX_POINTS];
    int                           path_len = 0;

    // Answers still owed by the block, oldest first.
    nearest_t expected_nearest[$];

    int error_count = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    int hold_left   = 0;

    // When set, neither side idles: requests go back to back and results
    // are taken as soon as they appear.
    logic steady = 1'b0;

    nearest_path_point_search #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_pos_x(s_pos_x),
        .s_pos_y(s_pos_y),
        .s_point_heading(s_point_heading),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_found(m_found),
        .m_nearest_index(m_nearest_index),
        .m_nearest_x(m_nearest_x),
        .m_nearest_y(m_nearest_y),
        .m_ref_heading(m_ref_heading),
        .m_dist_sq(m_dist_sq)
    );

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: a correct run finishes far below this bound, even with every
    // query scanning a full store behind the longest stalls.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Predicts the block's behaviour for one accepted request. A clear
    // empties the store, an append adds a point unless the store is full,
    // and a query scans the stored points in index order. The first point
    // at the least squared distance wins, so on a tie the lowest index is
    // kept. A query on an empty store gives a result with found low and
    // every other field zero. Kind 3 changes nothing.
    function automatic void predict_nearest(input logic [1:0] kind,
                                            input logic signed [COORD_BITS-1:0] px,
                                            input logic signed [COORD_BITS-1:0] py,
                                            input logic signed [HEAD_BITS-1:0] ph);
        nearest_t res;
        longint   dx;
        longint   dy;
        longint   d;
        longint   best;
        int       best_i;
        res = '0;
        best = 0;
        best_i = 0;
        case (kind)
            KIND_CLEAR: begin
                path_len = 0;
            end
            KIND_APPEND: begin
                if (path_len < MAX_POINTS) begin
                    path_x[path_len] = px;
                    path_y[path_len] = py;
                    path_heading[path_len] = ph;
                    path_len++;
                end
            end
            KIND_QUERY: begin
                if (path_len != 0) begin
                    for (int i = 0; i < path_len; i++) begin
                        dx = longint'(path_x[i]) - longint'(px);
                        dy = longint'(path_y[i]) - longint'(py);
                        d = dx * dx + dy * dy;
                        if (i == 0 || d < best) begin
                            best = d;
                            best_i = i;
                        end
                    end
                    // The comparison uses the full value; only the reported
                    // distance saturates.
                    if (best > DIST_MAX)
                        best = DIST_MAX;
                    res.found = 1'b1;
                    res.index = best_i[IDX_BITS-1:0];
                    res.x = path_x[best_i];
                    res.y = path_y[best_i];
                    res.heading = path_heading[best_i];
                    res.dist_sq = best[DIST_BITS-1:0];
                end
                expected_nearest.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Every result taken from the block is compared with the oldest answer
    // still owed. A result that nobody asked for is a failure in itself.
    always @(posedge aclk) begin : result_check
        nearest_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_nearest.size() == 0) begin
                $error("result with no query outstanding");
                error_count++;
            end else begin
                want = expected_nearest.pop_front();
                check_field("found", want.found, m_found);
                check_field("nearest_index", want.index, m_nearest_index);
                check_field("nearest_x", $signed(want.x), $signed(m_nearest_x));
                check_field("nearest_y", $signed(want.y), $signed(m_nearest_y));
                check_field("ref_heading", $signed(want.heading),
                            $signed(m_ref_heading));
                check_field("dist_sq", want.dist_sq, m_dist_sq);
            end
        end
    end

    // Result side back-pressure: mostly ready, short stalls now and then and
    // the odd long one, so that a finished result often has to wait.
    always @(posedge aclk) begin : result_stall
        int r;
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_ready <= 1'b1;
            end else if (r < 95) begin
                m_ready <= 1'b0;
                hold_left <= $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b0;
                hold_left <= $urandom_range(10, 60);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] any_coord();
        logic [31:0] r;
        r = $urandom();
        return r[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [HEAD_BITS-1:0] any_heading();
        logic [31:0] r;
        r = $urandom();
        return r[HEAD_BITS-1:0];
    endfunction

    // A coordinate within spread of base, clamped to the field's range.
    function automatic logic signed [COORD_BITS-1:0] near_coord(
            input logic signed [COORD_BITS-1:0] base, input int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < COORD_MIN)
            v = COORD_MIN;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[COORD_BITS-1:0];
    endfunction

    // Sends one request. Valid is raised at a clock edge, held with a steady
    // payload until the block accepts it, and only lowered when a gap comes
    // before the next request. The prediction is made at the accepting edge.
    task automatic send_request(input logic [1:0] kind,
                                input logic signed [COORD_BITS-1:0] px,
                                input logic signed [COORD_BITS-1:0] py,
                                input logic signed [HEAD_BITS-1:0] ph);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_pos_x <= px;
        s_pos_y <= py;
        s_point_heading <= ph;
        do @(posedge aclk); while (s_ready !== 1'b1);
        // Ignored requests do not count towards the stimulus total.
        if (kind != KIND_UNUSED && !(kind == KIND_APPEND && path_len >= MAX_POINTS))
            items_sent++;
        predict_nearest(kind, px, py, ph);
    endtask

    // Queries on an empty store, an unused kind that must leave the store
    // untouched, and a clear that really empties it.
    task automatic test_empty_store();
        send_request(KIND_QUERY, '0, '0, '0);
        send_request(KIND_UNUSED, any_coord(), any_coord(), any_heading());
        send_request(KIND_QUERY, any_coord(), any_coord(), any_heading());
        send_request(KIND_APPEND, 24'sd100, 24'sd200, 16'sd300);
        send_request(KIND_CLEAR, any_coord(), any_coord(), any_heading());
        send_request(KIND_QUERY, 24'sd100, 24'sd200, '0);
    endtask

    // Points and queries at the corners of the coordinate range, headings at
    // their extremes and in alternating bit patterns, and the largest
    // distance the fields can give.
    task automatic test_extremes();
        send_request(KIND_APPEND, COORD_MIN, COORD_MIN, 16'sh8000);
        send_request(KIND_APPEND, COORD_MAX, COORD_MAX, 16'sh7fff);
        send_request(KIND_APPEND, COORD_MAX, COORD_MIN, 16'sh5555);
        send_request(KIND_APPEND, COORD_MIN, COORD_MAX, 16'shaaaa);
        send_request(KIND_QUERY, COORD_MAX, COORD_MAX, '0);
        send_request(KIND_QUERY, COORD_MIN, COORD_MIN, '0);
        send_request(KIND_QUERY, '0, '0, '0);
        send_request(KIND_QUERY, -24'sd1, COORD_MAX, '0);
        send_request(KIND_CLEAR, '0, '0, '0);
        send_request(KIND_APPEND, COORD_MIN, COORD_MIN, -16'sd1);
        send_request(KIND_QUERY, COORD_MAX, COORD_MAX, '0);
    endtask

    // Equal distances: the lowest index must win, including against an
    // exact duplicate further up the store.
    task automatic test_ties();
        send_request(KIND_CLEAR, '0, '0, '0);
        send_request(KIND_APPEND, 24'sd256, '0, 16'sd11);
        send_request(KIND_APPEND, -24'sd256, '0, 16'sd22);
        send_request(KIND_APPEND, 24'sd256, '0, 16'sd33);
        send_request(KIND_QUERY, '0, '0, '0);
        send_request(KIND_QUERY, '0, 24'sd512, '0);
        send_request(KIND_QUERY, 24'sd256, '0, '0);
        send_request(KIND_QUERY, -24'sd256, '0, '0);
    endtask

    // Random paths. Most of the traffic is well-formed: an optional clear, a
    // run of appended points clustered around a centre (with the odd
    // duplicate to force ties), then a few queries on, near or far from the
    // stored points. The rest is noise: unused kinds, queries on an emptied
    // store, stray appends and queries with no preparation.
    task automatic test_random_paths();
        int start;
        int r;
        int k;
        int spread;
        int pick;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        start = items_sent;
        while (items_sent - start < 525) begin
            r = $urandom_range(0, 99);
            steady = ($urandom_range(0, 9) == 0);
            if (r < 85) begin
                if (path_len > 700 || $urandom_range(0, 2) != 0)
                    send_request(KIND_CLEAR, any_coord(), any_coord(), any_heading());
                k = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 250)
                                                 : $urandom_range(1, 12);
                spread = ($urandom_range(0, 3) == 0) ? COORD_MAX : $urandom_range(1, 4096);
                cx = any_coord();
                cy = any_coord();
                for (int i = 0; i < k; i++) begin
                    if (i > 0 && $urandom_range(0, 7) == 0) begin
                        pick = $urandom_range(0, path_len - 1);
                        send_request(KIND_APPEND, path_x[pick], path_y[pick], any_heading());
                    end else begin
                        send_request(KIND_APPEND, near_coord(cx, spread),
                                     near_coord(cy, spread), any_heading());
                    end
                end
                repeat ($urandom_range(1, 4)) begin
                    pick = $urandom_range(0, path_len - 1);
                    case ($urandom_range(0, 3))
                        0: send_request(KIND_QUERY, path_x[pick], path_y[pick],
                                        any_heading());
                        1: send_request(KIND_QUERY, near_coord(path_x[pick], 300),
                                        near_coord(path_y[pick], 300), any_heading());
                        2: send_request(KIND_QUERY, near_coord(cx, spread),
                                        near_coord(cy, spread), any_heading());
                        default: send_request(KIND_QUERY, any_coord(), any_coord(),
                                              any_heading());
                    endcase
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: send_request(KIND_UNUSED, any_coord(), any_coord(), any_heading());
                    1: begin
                        send_request(KIND_CLEAR, any_coord(), any_coord(), any_heading());
                        send_request(KIND_QUERY, any_coord(), any_coord(), any_heading());
                    end
                    2: send_request(KIND_APPEND, any_coord(), any_coord(), any_heading());
                    default: send_request(KIND_QUERY, any_coord(), any_coord(),
                                          any_heading());
                endcase
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        // Synchronous reset, held low at the start of the run.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_store();
        test_extremes();
        test_ties();
        test_random_paths();

        s_valid <= 1'b0;
        while (expected_nearest.size() != 0)
            @(posedge aclk);
        // Room for any stray result to show up before the verdict.
        repeat (20) @(posedge aclk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
